>>> rtl/crt_pkg.sv
package crt_pkg;

    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 25;
    localparam int SIZE_W = 11;

    // chunk index / chunk count width, sized for the smallest chunk shift
    localparam int CHUNK_SHIFT_MIN = 6;
    localparam int CNT_W           = LEN_W - CHUNK_SHIFT_MIN + 1;

    localparam int MAP_ENTRIES_DEF = 16384;
    localparam int CHUNK_SHIFT_DEF = 10;

    // received map is kept as rows of ROW_BITS flags
    localparam int ROW_BITS  = 16;
    localparam int ROW_BIT_W = 4;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_CHUNK  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  byte_count;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] missing_address;
        logic [SIZE_W-1:0] missing_size;
        logic              complete;
        logic              range_error;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_MARK,
        CMD_REJECT,
        CMD_FINISH
    } t_cmd_kind;

    // addr: base on begin/finish; idx: chunk index on mark, chunk count on finish
    typedef struct packed {
        t_cmd_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  idx;
        logic              err;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_q_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } t_back_state;

endpackage

>>> rtl/chunk_receipt_tracker.sv
// Chunk receipt tracker: keeps a bitmap of which chunks (1 << CHUNK_SHIFT bytes)
// of a block transfer have arrived. Requests enter through a 2-entry queue, so
// the input stays ready while the queue has room. Per request, in the back end:
// a chunk mark pops, reads its row and writes the row back on the map RAM;
// an out-of-range chunk is only popped; a begin clears the map one 16-flag row
// per cycle; a finish pops, then reads and checks one 16-chunk row at a time
// up to the first missing chunk, then loads the result register, passing the
// read state once more first when no chunk is missing. The result load waits
// while the previous result is still held. The map is not cleared at reset:
// its length is zero until the first begin, which clears it before any use.
module chunk_receipt_tracker #(
    parameter int MAP_ENTRIES = crt_pkg::MAP_ENTRIES_DEF,
    parameter int CHUNK_SHIFT = crt_pkg::CHUNK_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  crt_pkg::t_in_item  i_in,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output crt_pkg::t_out_item o_out,
    input  logic               i_out_ready
);

    crt_pkg::t_q_wr q_wr;
    crt_pkg::t_cmd  q_head;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    crt_front #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .CHUNK_SHIFT (CHUNK_SHIFT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_q_wr     (q_wr)
    );

    crt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    crt_back #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .CHUNK_SHIFT (CHUNK_SHIFT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_head    (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (i_out_ready)
    );

endmodule

>>> rtl/crt_front.sv
module crt_front #(
    parameter int MAP_ENTRIES = crt_pkg::MAP_ENTRIES_DEF,
    parameter int CHUNK_SHIFT = crt_pkg::CHUNK_SHIFT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  crt_pkg::t_in_item i_in,
    output logic              o_in_ready,
    input  logic              i_q_full,
    output crt_pkg::t_q_wr    o_q_wr
);

    localparam int LEN_W = crt_pkg::LEN_W;
    localparam int CNT_W = crt_pkg::CNT_W;
    localparam int CAP_W = $clog2(MAP_ENTRIES + 1) + CHUNK_SHIFT;
    localparam int CMP_W = (CAP_W > LEN_W) ? CAP_W : LEN_W;
    localparam logic [CMP_W-1:0] CAP = CMP_W'(MAP_ENTRIES) << CHUNK_SHIFT;
    localparam int CHUNK_MASK = (1 << CHUNK_SHIFT) - 1;

    logic [crt_pkg::ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]           r_len;

    logic                       accept;
    logic [crt_pkg::ADDR_W-1:0] offset;
    logic [crt_pkg::ADDR_W-1:0] chunk_idx;
    logic [LEN_W:0]             len_sum;
    logic [CNT_W-1:0]           chunk_cnt;
    logic [CNT_W-1:0]           map_n;
    logic                       over;
    logic [LEN_W-1:0]           sat_len;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        offset    = i_in.addr - r_base;
        chunk_idx = offset >> CHUNK_SHIFT;
        len_sum   = {1'b0, r_len} + (LEN_W + 1)'(CHUNK_MASK);
        chunk_cnt = CNT_W'(len_sum >> CHUNK_SHIFT);
        map_n     = (chunk_cnt > CNT_W'(MAP_ENTRIES)) ? CNT_W'(MAP_ENTRIES) : chunk_cnt;
        over      = CMP_W'(i_in.byte_count) > CAP;
        sat_len   = over ? CAP[LEN_W-1:0] : i_in.byte_count;
    end

    always_comb begin
        o_q_wr          = '0;
        o_q_wr.cmd.addr = i_in.addr;
        o_q_wr.cmd.len  = sat_len;
        unique case (i_in.op)
            crt_pkg::OP_BEGIN: begin
                o_q_wr.push     = accept;
                o_q_wr.cmd.kind = crt_pkg::CMD_BEGIN;
                o_q_wr.cmd.err  = over;
            end
            crt_pkg::OP_CHUNK: begin
                o_q_wr.push     = accept;
                // an address below base wraps to a huge index and lands here too
                o_q_wr.cmd.kind = (chunk_idx < crt_pkg::ADDR_W'(map_n)) ?
                                  crt_pkg::CMD_MARK : crt_pkg::CMD_REJECT;
                o_q_wr.cmd.idx  = chunk_idx[CNT_W-1:0];
            end
            crt_pkg::OP_FINISH: begin
                o_q_wr.push     = accept;
                o_q_wr.cmd.kind = crt_pkg::CMD_FINISH;
                o_q_wr.cmd.addr = r_base;
                o_q_wr.cmd.len  = r_len;
                o_q_wr.cmd.idx  = map_n;
            end
            default: begin
                o_q_wr.push     = 1'b0;
                o_q_wr.cmd.kind = crt_pkg::CMD_REJECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_len  <= '0;
        end else if (accept && i_in.op == crt_pkg::OP_BEGIN) begin
            r_base <= i_in.addr;
            r_len  <= sat_len;
        end
    end

endmodule

>>> rtl/crt_queue.sv
module crt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  crt_pkg::t_q_wr i_wr,
    input  logic           i_pop,
    output crt_pkg::t_cmd  o_head,
    output logic           o_full,
    output logic           o_empty
);

    localparam int DEPTH = crt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crt_pkg::t_cmd    r_ent [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_ent[r_rd_ptr];
    assign do_push = i_wr.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr_ptr] <= i_wr.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_full)
        else $error("request pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule

>>> rtl/crt_back.sv
module crt_back #(
    parameter int MAP_ENTRIES = crt_pkg::MAP_ENTRIES_DEF,
    parameter int CHUNK_SHIFT = crt_pkg::CHUNK_SHIFT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crt_pkg::t_cmd      i_q_head,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output crt_pkg::t_out_item o_out,
    input  logic               i_out_ready
);

    localparam int ADDR_W    = crt_pkg::ADDR_W;
    localparam int LEN_W     = crt_pkg::LEN_W;
    localparam int CNT_W     = crt_pkg::CNT_W;
    localparam int SIZE_W    = crt_pkg::SIZE_W;
    localparam int ROW_BITS  = crt_pkg::ROW_BITS;
    localparam int ROW_BIT_W = crt_pkg::ROW_BIT_W;
    localparam int ROWS      = (MAP_ENTRIES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CHUNK_BYTES = 1 << CHUNK_SHIFT;

    crt_pkg::t_back_state r_state;
    crt_pkg::t_back_state n_state;

    logic [ROW_BITS-1:0] r_mem [ROWS];
    logic [ROW_BITS-1:0] r_rd_data;

    logic [ADDR_W-1:0]   r_base;
    logic [LEN_W-1:0]    r_len;
    logic [CNT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_n;
    logic [ROW_AW:0]     r_row;
    logic                r_found;
    logic                r_err;
    logic                r_out_valid;
    crt_pkg::t_out_item  r_out;

    logic                mem_rd_en;
    logic [ROW_AW-1:0]   mem_rd_addr;
    logic                mem_wr_en;
    logic [ROW_AW-1:0]   mem_wr_addr;
    logic [ROW_BITS-1:0] mem_wr_data;

    logic [CNT_W-1:0]     scan_base;
    logic                 scan_done;
    logic [CNT_W-1:0]     scan_lim;
    logic [ROW_BITS-1:0]  zero_vec;
    logic [ROW_BIT_W-1:0] first_bit;
    logic                 found_any;
    logic                 out_free;
    logic                 last_row;
    logic [ROW_AW-1:0]    idx_row;
    logic [ROW_BITS-1:0]  idx_bit;

    logic [ADDR_W-1:0]   start;
    logic [ADDR_W-1:0]   miss_addr;
    logic [LEN_W-1:0]    left;
    logic [LEN_W-1:0]    miss_size;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign last_row    = (r_row == (ROW_AW + 1)'(ROWS - 1));
    assign idx_row     = ROW_AW'(r_idx >> ROW_BIT_W);
    assign idx_bit     = ROW_BITS'(1) << r_idx[ROW_BIT_W-1:0];

    // scan of one row: chunks at or past the count are treated as present
    always_comb begin
        scan_base = CNT_W'({r_row, {ROW_BIT_W{1'b0}}});
        scan_done = (scan_base >= r_n);
        scan_lim  = r_n - scan_base;
        for (int b = 0; b < ROW_BITS; b++) begin
            zero_vec[b] = !r_rd_data[b] && (CNT_W'(b) < scan_lim);
        end
        first_bit = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (zero_vec[b]) begin
                first_bit = ROW_BIT_W'(b);
            end
        end
        found_any = |zero_vec;
    end

    always_comb begin
        start     = ADDR_W'(r_idx) << CHUNK_SHIFT;
        miss_addr = r_base + start;
        left      = r_len - start[LEN_W-1:0];
        miss_size = (left < LEN_W'(CHUNK_BYTES)) ? left : LEN_W'(CHUNK_BYTES);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crt_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_head.kind)
                        crt_pkg::CMD_BEGIN:  n_state = crt_pkg::ST_CLEAR;
                        crt_pkg::CMD_MARK:   n_state = crt_pkg::ST_MARK_RD;
                        crt_pkg::CMD_FINISH: n_state = crt_pkg::ST_SCAN_RD;
                        default:             n_state = crt_pkg::ST_IDLE;
                    endcase
                end
            end
            crt_pkg::ST_CLEAR:    n_state = last_row ? crt_pkg::ST_IDLE : crt_pkg::ST_CLEAR;
            crt_pkg::ST_MARK_RD:  n_state = crt_pkg::ST_MARK_WR;
            crt_pkg::ST_MARK_WR:  n_state = crt_pkg::ST_IDLE;
            crt_pkg::ST_SCAN_RD:  n_state = scan_done ? crt_pkg::ST_EMIT : crt_pkg::ST_SCAN_CHK;
            crt_pkg::ST_SCAN_CHK: n_state = found_any ? crt_pkg::ST_EMIT : crt_pkg::ST_SCAN_RD;
            crt_pkg::ST_EMIT:     n_state = out_free ? crt_pkg::ST_IDLE : crt_pkg::ST_EMIT;
            default:              n_state = crt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop     = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_row[ROW_AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_row[ROW_AW-1:0];
        mem_wr_data = '0;
        unique case (r_state)
            crt_pkg::ST_IDLE:  o_q_pop = !i_q_empty;
            crt_pkg::ST_CLEAR: mem_wr_en = 1'b1;
            crt_pkg::ST_MARK_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_row;
            end
            crt_pkg::ST_MARK_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_row;
                mem_wr_data = r_rd_data | idx_bit;
            end
            crt_pkg::ST_SCAN_RD: mem_rd_en = !scan_done;
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (o_q_pop) begin
            if (i_q_head.kind == crt_pkg::CMD_BEGIN) begin
                r_err <= i_q_head.err;
            end else if (i_q_head.kind == crt_pkg::CMD_REJECT) begin
                r_err <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_base  <= i_q_head.addr;
            r_len   <= i_q_head.len;
            r_idx   <= i_q_head.idx;
            r_n     <= i_q_head.idx;
            r_row   <= '0;
            r_found <= 1'b0;
        end else if (r_state == crt_pkg::ST_CLEAR) begin
            r_row <= r_row + 1'b1;
        end else if (r_state == crt_pkg::ST_SCAN_CHK) begin
            if (found_any) begin
                r_idx   <= scan_base + CNT_W'(first_bit);
                r_found <= 1'b1;
            end else begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == crt_pkg::ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == crt_pkg::ST_EMIT && out_free) begin
            r_out.range_error <= r_err;
            if (r_found) begin
                r_out.missing_address <= miss_addr;
                r_out.missing_size    <= miss_size[SIZE_W-1:0];
                r_out.complete        <= 1'b0;
            end else begin
                r_out.missing_address <= '0;
                r_out.missing_size    <= '0;
                r_out.complete        <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_mark_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == crt_pkg::ST_MARK_WR |-> $past(r_state) == crt_pkg::ST_MARK_RD)
        else $error("map write-back without its read");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == crt_pkg::ST_SCAN_CHK |-> scan_base < r_n)
        else $error("scan checked a row past the chunk count");

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == crt_pkg::ST_EMIT && r_found |-> r_idx < r_n)
        else $error("missing chunk index beyond chunk count");

    a_complete_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.complete |->
            o_out.missing_address == '0 && o_out.missing_size == '0)
        else $error("complete result carries a missing chunk");
`endif

endmodule
